// File: src/pett_pkg.sv
// ----------------------------------------------------------------------------
// pett_pkg: shared types for the periodic event timer table
// Item structs, command and status codes, controller state and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pett_pkg;

  // default configuration
  localparam int unsigned SLOTS_DEF     = 16;
  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned TAG_BITS_DEF  = 16;

  // command codes carried in the input item
  typedef enum logic [2:0] {
    CMD_ADD_PER = 3'd0,
    CMD_ADD_ONE = 3'd1,
    CMD_DELETE  = 3'd2,
    CMD_UPDATE  = 3'd3,
    CMD_RUN     = 3'd4,
    CMD_SETBACK = 3'd5
  } cmd_e;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] tag;
    logic [31:0] amount;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic [15:0] fired_tag;
    logic [31:0] next_due;
    logic        next_due_valid;
    logic        last;
  } out_item_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_MIN,
    S_SEEK,
    S_READ
  } ctl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic clr_cnt;
    logic step_cnt;
    logic scan_en;
    logic act_en;
    logic min_en;
    logic emit_fire;
    logic emit_status;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pass_done;
    logic fired_here;
    logic none_fired;
    logic remain_one;
    logic out_free;
  } ctl_status_t;

endpackage

// File: src/pett_ctrl.sv
// ----------------------------------------------------------------------------
// pett_ctrl: sequencer for the timer table
// Walks each item through the slot scan, the table update, the minimum
// pass and the result emission.
// ----------------------------------------------------------------------------
module pett_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pett_pkg::ctl_status_t status_i,
  output pett_pkg::ctl_cmd_t    cmd_o
);
  import pett_pkg::*;

  ctl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (status_i.pass_done) state_d = S_ACT;
      end
      S_ACT: begin
        state_d = S_MIN;
      end
      S_MIN: begin
        if (status_i.pass_done) state_d = S_SEEK;
      end
      S_SEEK: begin
        if (status_i.none_fired) begin
          if (status_i.out_free) state_d = S_IDLE;
        end else if (status_i.fired_here) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (status_i.out_free) state_d = status_i.remain_one ? S_IDLE : S_SEEK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
        cmd_o.clr_cnt   = 1'b1;
      end
      S_SCAN: begin
        cmd_o.scan_en  = 1'b1;
        cmd_o.step_cnt = 1'b1;
      end
      S_ACT: begin
        cmd_o.act_en  = 1'b1;
        cmd_o.clr_cnt = 1'b1;
      end
      S_MIN: begin
        cmd_o.min_en   = 1'b1;
        cmd_o.step_cnt = 1'b1;
        cmd_o.clr_cnt  = status_i.pass_done;
      end
      S_SEEK: begin
        if (status_i.none_fired) begin
          cmd_o.emit_status = status_i.out_free;
        end else begin
          cmd_o.step_cnt = !status_i.fired_here;
        end
      end
      S_READ: begin
        cmd_o.emit_fire = status_i.out_free;
        cmd_o.step_cnt  = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: src/pett_dpath.sv
// ----------------------------------------------------------------------------
// pett_dpath: slot storage and arithmetic for the timer table
// Holds the slot memories, armed and fired flags, the slot counter, the
// search and minimum registers, and the output register.
// ----------------------------------------------------------------------------
module pett_dpath #(
  parameter int unsigned SLOTS     = pett_pkg::SLOTS_DEF,
  parameter int unsigned TIME_BITS = pett_pkg::TIME_BITS_DEF,
  parameter int unsigned TAG_BITS  = pett_pkg::TAG_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pett_pkg::in_item_t    in_item_i,
  input  pett_pkg::ctl_cmd_t    cmd_i,
  output pett_pkg::ctl_status_t status_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output pett_pkg::out_item_t   out_item_o
);
  import pett_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef logic [TIME_BITS-1:0] time_t;

  function automatic time_t sat_add(input time_t a, input time_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

  // slot memories
  logic [TAG_BITS-1:0] tag_mem [SLOTS];
  time_t               due_mem [SLOTS];
  time_t               per_mem [SLOTS];
  logic [TAG_BITS-1:0] tag_rd_q;
  time_t               due_rd_q;
  time_t               per_rd_q;

  // control and working registers
  logic [SLOTS-1:0] armed_q, armed_d;
  logic [SLOTS-1:0] fired_q, fired_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    nfired_q, nfired_d;
  logic             proc_vld_q;
  logic [IW-1:0]    proc_idx_q;
  logic             free_found_q, free_found_d;
  logic [IW-1:0]    free_idx_q, free_idx_d;
  logic             match_found_q, match_found_d;
  logic [IW-1:0]    match_idx_q, match_idx_d;
  time_t            match_due_q, match_due_d;
  logic             best_vld_q, best_vld_d;
  time_t            best_q, best_d;
  logic [1:0]       stat_q, stat_d;
  in_item_t         item_q;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  // item fields at internal widths
  logic [TAG_BITS-1:0] tag_w;
  time_t               amt_w, now_w, ival_w;
  assign tag_w  = TAG_BITS'(item_q.tag);
  assign amt_w  = TIME_BITS'(item_q.amount);
  assign now_w  = TIME_BITS'(item_q.now);
  assign ival_w = (amt_w == '0) ? TIME_BITS'(1) : amt_w;

  logic [IW-1:0] rd_addr;
  logic          cnt_live;
  logic          proc_armed;
  assign cnt_live   = cnt_q < CW'(SLOTS);
  assign rd_addr    = cnt_live ? cnt_q[IW-1:0] : '0;
  assign proc_armed = armed_q[proc_idx_q];

  // memory write port controls
  logic                we_tag, we_due, we_per;
  logic [IW-1:0]       wa_due, wa_slot;
  time_t               wd_due, wd_per;
  logic [TAG_BITS-1:0] wd_tag;

  // slot processing, table update and minimum
  always_comb begin
    armed_d       = armed_q;
    fired_d       = fired_q;
    nfired_d      = nfired_q;
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    match_due_d   = match_due_q;
    best_vld_d    = best_vld_q;
    best_d        = best_q;
    stat_d        = stat_q;
    we_tag        = 1'b0;
    we_due        = 1'b0;
    we_per        = 1'b0;
    wa_due        = proc_idx_q;
    wa_slot       = free_idx_q;
    wd_due        = sat_add(now_w, per_rd_q);
    wd_per        = ival_w;
    wd_tag        = tag_w;

    if (cmd_i.load_item) begin
      fired_d       = '0;
      nfired_d      = '0;
      free_found_d  = 1'b0;
      match_found_d = 1'b0;
      stat_d        = ST_OK;
    end

    // per-slot scan
    if (cmd_i.scan_en && proc_vld_q) begin
      case (item_q.command)
        CMD_ADD_PER, CMD_ADD_ONE: begin
          if (!proc_armed && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = proc_idx_q;
          end
        end
        CMD_DELETE, CMD_UPDATE: begin
          if (proc_armed && tag_rd_q == tag_w && !match_found_q) begin
            match_found_d = 1'b1;
            match_idx_d   = proc_idx_q;
            match_due_d   = due_rd_q;
          end
        end
        CMD_RUN: begin
          if (proc_armed && due_rd_q <= now_w) begin
            fired_d[proc_idx_q] = 1'b1;
            nfired_d            = nfired_q + CW'(1);
            if (per_rd_q != '0) begin
              we_due = 1'b1;
            end else begin
              armed_d[proc_idx_q] = 1'b0;
            end
          end
        end
        CMD_SETBACK: begin
          if (proc_armed) begin
            we_due = 1'b1;
            wd_due = (due_rd_q > amt_w) ? due_rd_q - amt_w : '0;
          end
        end
        default: begin
        end
      endcase
    end

    // table update after the scan
    if (cmd_i.act_en) begin
      best_vld_d = 1'b0;
      best_d     = '0;
      case (item_q.command)
        CMD_ADD_PER, CMD_ADD_ONE: begin
          if (free_found_q) begin
            armed_d[free_idx_q] = 1'b1;
            we_tag = 1'b1;
            we_due = 1'b1;
            we_per = 1'b1;
            wa_due = free_idx_q;
            wd_due = sat_add(now_w, ival_w);
            wd_per = (item_q.command == CMD_ADD_PER) ? ival_w : '0;
          end else begin
            stat_d = ST_FULL;
          end
        end
        CMD_DELETE: begin
          if (match_found_q) armed_d[match_idx_q] = 1'b0;
          else stat_d = ST_NOTFOUND;
        end
        CMD_UPDATE: begin
          if (match_found_q) begin
            wa_slot = match_idx_q;
            wa_due  = match_idx_q;
            we_per  = 1'b1;
            wd_per  = amt_w;
            wd_due  = sat_add(now_w, amt_w);
            we_due  = wd_due < match_due_q;
          end else begin
            stat_d = ST_NOTFOUND;
          end
        end
        default: begin
        end
      endcase
    end

    // earliest due time over armed slots
    if (cmd_i.min_en && proc_vld_q && proc_armed) begin
      if (!best_vld_q || due_rd_q < best_q) begin
        best_vld_d = 1'b1;
        best_d     = due_rd_q;
      end
    end

    if (cmd_i.emit_fire) nfired_d = nfired_q - CW'(1);
  end

  // slot counter
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clr_cnt) cnt_d = '0;
    else if (cmd_i.step_cnt && cnt_live) cnt_d = cnt_q + CW'(1);
  end

  // output register load
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.emit_status || cmd_i.emit_fire) begin
      out_valid_d        = 1'b1;
      out_d.next_due       = 32'(best_q);
      out_d.next_due_valid = best_vld_q;
      if (cmd_i.emit_fire) begin
        out_d.status    = ST_OK;
        out_d.fired     = 1'b1;
        out_d.fired_tag = 16'(tag_rd_q);
        out_d.last      = nfired_q == CW'(1);
      end else begin
        out_d.status    = stat_q;
        out_d.fired     = 1'b0;
        out_d.fired_tag = '0;
        out_d.last      = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q       <= '0;
      fired_q       <= '0;
      nfired_q      <= '0;
      cnt_q         <= '0;
      proc_vld_q    <= 1'b0;
      free_found_q  <= 1'b0;
      match_found_q <= 1'b0;
      best_vld_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      armed_q       <= armed_d;
      fired_q       <= fired_d;
      nfired_q      <= nfired_d;
      cnt_q         <= cnt_d;
      proc_vld_q    <= (cmd_i.scan_en || cmd_i.min_en) && cnt_live && !cmd_i.clr_cnt;
      free_found_q  <= free_found_d;
      match_found_q <= match_found_d;
      best_vld_q    <= best_vld_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= in_item_i;
    proc_idx_q  <= rd_addr;
    free_idx_q  <= free_idx_d;
    match_idx_q <= match_idx_d;
    match_due_q <= match_due_d;
    best_q      <= best_d;
    stat_q      <= stat_d;
    out_q       <= out_d;
  end

  // slot memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_tag) tag_mem[wa_slot] <= wd_tag;
    if (we_per) per_mem[wa_slot] <= wd_per;
    if (we_due) due_mem[wa_due] <= wd_due;
    tag_rd_q <= tag_mem[rd_addr];
    due_rd_q <= due_mem[rd_addr];
    per_rd_q <= per_mem[rd_addr];
  end

  // status to the controller
  assign status_o.pass_done  = proc_vld_q && (proc_idx_q == IW'(SLOTS - 1));
  assign status_o.fired_here = fired_q[rd_addr];
  assign status_o.none_fired = nfired_q == '0;
  assign status_o.remain_one = nfired_q == CW'(1);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: src/periodic_event_timer_table.sv
// ----------------------------------------------------------------------------
// periodic_event_timer_table: table of periodic and one-shot timers
// Top level joining the sequencer and the slot datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) takes one command item:
//   add periodic, add one-shot, delete, update period, run or set back.
//   Output channel (out_valid_o/out_ready_i/out_item_o) returns one result,
//   or one result per fired slot for a run, in slot order; the final result
//   of an item has last set. Every result carries the earliest due time.
//   Sequence: an item is taken only while the block is idle. It then goes
//   through the slot scan, the table update, the minimum pass and emission.
//   A run adds a seek over the slots and a read for each fired slot. The
//   pace is set by the single read port of the slot memories, walked once
//   per pass.
//   Stall: results wait in the output register; emission pauses while the
//   receiver holds off, and the next item is taken once the last result
//   sits in that register.
//   Reset: all slots are free and the output is empty.
module periodic_event_timer_table #(
  parameter int unsigned SLOTS     = pett_pkg::SLOTS_DEF,
  parameter int unsigned TIME_BITS = pett_pkg::TIME_BITS_DEF,
  parameter int unsigned TAG_BITS  = pett_pkg::TAG_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pett_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pett_pkg::out_item_t out_item_o
);
  import pett_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  pett_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pett_dpath #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS),
    .TAG_BITS  (TAG_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// File: src/pett_checker.sv
// ----------------------------------------------------------------------------
// pett_assert: port-level checks for the timer table
// Watches the top-level channels and is bound to every instance.
// ----------------------------------------------------------------------------
module pett_assert (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input pett_pkg::out_item_t out_item_o
);
  import pett_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  // one item at a time: no second accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while previous item still in work");

  // a result without a fired slot is the only one of its item
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.fired |-> out_item_o.last && out_item_o.fired_tag == '0)
    else $error("non-fired result not final or has a tag");

  // fired results always carry ok status
  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.fired |-> out_item_o.status == ST_OK)
    else $error("fired result with error status");

endmodule

bind periodic_event_timer_table pett_assert u_pett_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
